@@ src/vsl_pkg.sv @@
`timescale 1ns / 1ps

package vsl_pkg;

    localparam int unsigned US_PER_S = 1000000;
    localparam int unsigned RAD20_Q24 = 5856338;
    localparam int unsigned TAU_RESET = 100000;

    typedef enum logic [1:0]
    {
        REG_MAX_HORIZ = 2'd0,
        REG_MAX_VERT  = 2'd1,
        REG_MAX_TURN  = 2'd2,
        REG_TAU       = 2'd3
    } reg_idx_t;

    typedef enum logic
    {
        CMD_ACTIVATE = 1'b0,
        CMD_UPDATE   = 1'b1
    } cmd_t;

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_MUL_X,
        S_MUL_Y,
        S_MUL_L,
        S_CMP,
        S_SQRT,
        S_SC_MUL,
        S_SC_DIV,
        S_CLAMP,
        S_ACC_MUL,
        S_ACC_DIV,
        S_STP_MUL,
        S_STP_DIV,
        S_EMIT
    } state_t;

    typedef struct packed
    {
        logic               cmd;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] turn_rate;
        logic [19:0]        step_time_us;
    } in_t;

    typedef struct packed
    {
        logic signed [31:0] lim_vel_x;
        logic signed [31:0] lim_vel_y;
        logic signed [31:0] lim_vel_z;
        logic signed [31:0] lim_turn_rate;
        logic signed [31:0] accel_x;
        logic signed [31:0] accel_y;
        logic signed [31:0] accel_z;
    } out_t;

    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        logic [32:0] w;
        begin
            w = {v[31], v};
            abs32 = v[31] ? 32'(-w) : w[31:0];
        end
    endfunction

    function automatic logic [32:0] abs33(input logic signed [32:0] v);
        begin
            abs33 = v[32] ? 33'(-v) : 33'(v);
        end
    endfunction

    function automatic logic signed [31:0] clamp_sym(input logic signed [31:0] v,
                                                     input logic [30:0] lim);
        logic signed [32:0] l;
        logic signed [32:0] vx;
        begin
            l  = $signed({2'b00, lim});
            vx = {v[31], v};
            if (vx > l)
                clamp_sym = 32'(l);
            else if (vx < -l)
                clamp_sym = 32'(-l);
            else
                clamp_sym = v;
        end
    endfunction

    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        begin
            if (v > 34'sd2147483647)
                sat34 = 32'sh7FFF_FFFF;
            else if (v < -34'sd2147483648)
                sat34 = 32'sh8000_0000;
            else
                sat34 = v[31:0];
        end
    endfunction

endpackage

@@ src/velocity_setpoint_limit_accel_filter_core.sv @@
`timescale 1ns / 1ps

// Velocity setpoint limiter with low-passed acceleration. An update beat
// (cmd=1) scales (x,y) down to max_horiz_speed, clamps z and yaw rate, forms
// raw accel = (v - prev_vel) * 1e6 / dt (zero when dt is zero) and smooths it
// with alpha = dt/(dt+tau); one result beat follows. An activate beat (cmd=0)
// loads prev_vel with the raw velocities, clears the filter and gives no
// result. One item at a time: in_ready is high only while the sequencer is
// idle. Timing is set by a shared 64-step divider and a 32-step square root:
// each division is an operand step followed by waiting on the divider. An
// update without horizontal scaling runs six divisions plus six other steps
// from acceptance to the result beat; with scaling it adds the square root
// and two divisions. An axis with zero dt skips its acceleration division,
// and zero dt with zero tau skips the filter division too. While an earlier
// result beat is stalled, the sequencer waits in its emit state. Activate
// completes in the idle state. All values Q(32-FRAC_BITS).FRAC_BITS,
// saturating. Registers on APB: 0x0 max_horiz_speed, 0x4 max_vert_speed,
// 0x8 max_turn_rate, 0xC filter_time_const_us; write only while idle.
module velocity_setpoint_limit_accel_filter_core
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  vsl_pkg::in_t in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output vsl_pkg::out_t out_data,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import vsl_pkg::*;

    localparam logic [30:0] SPEED_RESET = 31'(1 << (FRAC_BITS - 1));
    localparam logic [30:0] TURN_RESET  =
        31'((RAD20_Q24 + ((1 << (24 - FRAC_BITS)) >> 1)) >> (24 - FRAC_BITS));

    // configuration
    logic [30:0] max_horiz_reg;
    logic [30:0] max_vert_reg;
    logic [30:0] max_turn_reg;
    logic [23:0] tau_reg;

    state_t state_reg, state_next;

    // working set
    logic signed [31:0] v_reg [3];
    logic signed [31:0] yaw_reg;
    logic [19:0]        dt_reg;
    logic [63:0]        acc_reg;
    logic [63:0]        mag2_reg;
    logic [31:0]        mag_reg;
    logic signed [31:0] raw_reg;
    logic               neg_reg;
    logic [1:0]         ax_reg;
    logic signed [31:0] prev_reg [3];
    logic signed [31:0] smooth_reg [3];
    logic               out_valid_reg;
    out_t               out_reg;

    // shared multiplier
    logic [32:0] mul_a;
    logic [31:0] mul_b;
    logic [64:0] mul_p;

    logic        div_start;
    logic        div_done;
    logic [63:0] div_dvd;
    logic [31:0] div_dvs;
    logic [63:0] div_q;
    logic        sqrt_start;
    logic        sqrt_done;
    logic [31:0] sqrt_root;

    logic signed [32:0] diff;
    logic signed [32:0] err;
    logic [24:0]        den;
    logic               ax_last;
    logic               scale_last;
    logic               emit_go;
    logic               cfg_wr;

    assign mul_p      = 65'(mul_a) * 65'(mul_b);
    assign diff       = 33'(v_reg[ax_reg]) - 33'(prev_reg[ax_reg]);
    assign err        = 33'(raw_reg) - 33'(smooth_reg[ax_reg]);
    assign den        = 25'(dt_reg) + 25'(tau_reg);
    assign ax_last    = ax_reg == 2'd2;
    assign scale_last = ax_reg == 2'd1;
    assign emit_go    = !out_valid_reg || out_ready;
    assign cfg_wr     = psel && penable && pwrite;

    vsl_divu u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    vsl_isqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (mag2_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid && in_data.cmd == CMD_UPDATE)
                    state_next = S_MUL_X;
            S_MUL_X:  state_next = S_MUL_Y;
            S_MUL_Y:  state_next = S_MUL_L;
            S_MUL_L:  state_next = S_CMP;
            S_CMP:    state_next = (mag2_reg > acc_reg) ? S_SQRT : S_CLAMP;
            S_SQRT:
                if (sqrt_done)
                    state_next = S_SC_MUL;
            S_SC_MUL: state_next = S_SC_DIV;
            S_SC_DIV:
                if (div_done)
                    state_next = scale_last ? S_CLAMP : S_SC_MUL;
            S_CLAMP:  state_next = S_ACC_MUL;
            S_ACC_MUL: state_next = (dt_reg == '0) ? S_STP_MUL : S_ACC_DIV;
            S_ACC_DIV:
                if (div_done)
                    state_next = S_STP_MUL;
            S_STP_MUL:
                if (den != '0)
                    state_next = S_STP_DIV;
                else
                    state_next = ax_last ? S_EMIT : S_ACC_MUL;
            S_STP_DIV:
                if (div_done)
                    state_next = ax_last ? S_EMIT : S_ACC_MUL;
            S_EMIT:
                if (emit_go)
                    state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // unit operands and starts
    always_comb
    begin
        mul_a      = '0;
        mul_b      = '0;
        div_start  = 1'b0;
        div_dvd    = 64'(mul_p);
        div_dvs    = '0;
        sqrt_start = 1'b0;
        unique case (state_reg)
            S_MUL_X:
            begin
                mul_a = 33'(abs32(v_reg[0]));
                mul_b = abs32(v_reg[0]);
            end
            S_MUL_Y:
            begin
                mul_a = 33'(abs32(v_reg[1]));
                mul_b = abs32(v_reg[1]);
            end
            S_MUL_L:
            begin
                mul_a = 33'(max_horiz_reg);
                mul_b = 32'(max_horiz_reg);
            end
            S_CMP:
                sqrt_start = mag2_reg > acc_reg;
            S_SC_MUL:
            begin
                mul_a     = 33'(abs32(v_reg[ax_reg]));
                mul_b     = 32'(max_horiz_reg);
                div_start = 1'b1;
                div_dvs   = mag_reg;
            end
            S_ACC_MUL:
            begin
                mul_a     = abs33(diff);
                mul_b     = 32'(US_PER_S);
                div_start = dt_reg != '0;
                div_dvs   = 32'(dt_reg);
            end
            S_STP_MUL:
            begin
                mul_a     = abs33(err);
                mul_b     = 32'(dt_reg);
                div_start = den != '0;
                div_dvs   = 32'(den);
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            max_horiz_reg <= SPEED_RESET;
            max_vert_reg  <= SPEED_RESET;
            max_turn_reg  <= TURN_RESET;
            tau_reg       <= 24'(TAU_RESET);
            out_valid_reg <= 1'b0;
            ax_reg        <= '0;
            for (int i = 0; i < 3; i++)
            begin
                prev_reg[i]   <= '0;
                smooth_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr)
            begin
                unique case (reg_idx_t'(paddr[3:2]))
                    REG_MAX_HORIZ: max_horiz_reg <= pwdata[30:0];
                    REG_MAX_VERT:  max_vert_reg  <= pwdata[30:0];
                    REG_MAX_TURN:  max_turn_reg  <= pwdata[30:0];
                    REG_TAU:       tau_reg       <= pwdata[23:0];
                    default:       tau_reg       <= tau_reg;
                endcase
            end

            // a new beat may replace one leaving in the same cycle
            if (state_reg == S_EMIT && emit_go)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                    if (in_valid && in_data.cmd == CMD_ACTIVATE)
                    begin
                        prev_reg[0] <= in_data.vel_x;
                        prev_reg[1] <= in_data.vel_y;
                        prev_reg[2] <= in_data.vel_z;
                        for (int i = 0; i < 3; i++)
                            smooth_reg[i] <= '0;
                    end
                S_SQRT:
                    ax_reg <= '0;
                S_SC_DIV:
                    if (div_done)
                        ax_reg <= ax_reg + 2'd1;
                S_CLAMP:
                    ax_reg <= '0;
                S_ACC_MUL:
                    prev_reg[ax_reg] <= v_reg[ax_reg];
                S_STP_MUL:
                    if (den == '0)
                        ax_reg <= ax_reg + 2'd1;
                S_STP_DIV:
                    if (div_done)
                    begin
                        smooth_reg[ax_reg] <= sat34(34'(smooth_reg[ax_reg]) +
                            (neg_reg ? -$signed({1'b0, div_q[32:0]})
                                     : $signed({1'b0, div_q[32:0]})));
                        ax_reg <= ax_reg + 2'd1;
                    end
                default:
                    ax_reg <= ax_reg;
            endcase
        end
    end

    // payload path
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
                if (in_valid && in_data.cmd == CMD_UPDATE)
                begin
                    v_reg[0] <= in_data.vel_x;
                    v_reg[1] <= in_data.vel_y;
                    v_reg[2] <= in_data.vel_z;
                    yaw_reg  <= in_data.turn_rate;
                    dt_reg   <= in_data.step_time_us;
                end
            S_MUL_X:  acc_reg  <= mul_p[63:0];
            S_MUL_Y:  mag2_reg <= acc_reg + mul_p[63:0];
            S_MUL_L:  acc_reg  <= mul_p[63:0];
            S_SQRT:
                if (sqrt_done)
                    mag_reg <= sqrt_root;
            S_SC_MUL: neg_reg  <= v_reg[ax_reg][31];
            S_SC_DIV:
                if (div_done)
                    v_reg[ax_reg] <= neg_reg ? 32'(-div_q[31:0]) : div_q[31:0];
            S_CLAMP:
            begin
                v_reg[2] <= clamp_sym(v_reg[2], max_vert_reg);
                yaw_reg  <= clamp_sym(yaw_reg, max_turn_reg);
            end
            S_ACC_MUL:
            begin
                neg_reg <= diff[32];
                if (dt_reg == '0)
                    raw_reg <= '0;
            end
            S_ACC_DIV:
                if (div_done)
                begin
                    if (neg_reg)
                        raw_reg <= (div_q > 64'h8000_0000) ? 32'sh8000_0000
                                                           : 32'(-div_q[31:0]);
                    else
                        raw_reg <= (div_q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF
                                                           : div_q[31:0];
                end
            S_STP_MUL: neg_reg <= err[32];
            S_EMIT:
                if (emit_go)
                begin
                    out_reg.lim_vel_x     <= v_reg[0];
                    out_reg.lim_vel_y     <= v_reg[1];
                    out_reg.lim_vel_z     <= v_reg[2];
                    out_reg.lim_turn_rate <= yaw_reg;
                    out_reg.accel_x       <= smooth_reg[0];
                    out_reg.accel_y       <= smooth_reg[1];
                    out_reg.accel_z       <= smooth_reg[2];
                end
            default:
                acc_reg <= acc_reg;
        endcase
    end

    // register readback
    always_comb
    begin
        unique case (reg_idx_t'(paddr[3:2]))
            REG_MAX_HORIZ: prdata = {1'b0, max_horiz_reg};
            REG_MAX_VERT:  prdata = {1'b0, max_vert_reg};
            REG_MAX_TURN:  prdata = {1'b0, max_turn_reg};
            REG_TAU:       prdata = {8'd0, tau_reg};
            default:       prdata = '0;
        endcase
    end

    assign pready    = 1'b1;
    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

@@ src/vsl_divu.sv @@
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module vsl_divu
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);
    import vsl_pkg::*;

    logic [63:0] q_reg;
    logic [31:0] rem_reg;
    logic [31:0] dvs_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] trial;
    logic        fits;

    assign trial = {rem_reg, q_reg[63]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? 32'(trial - {1'b0, dvs_reg}) : trial[31:0];
            q_reg   <= {q_reg[62:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

@@ src/vsl_isqrt.sv @@
`timescale 1ns / 1ps

// floor square root, one result bit per cycle
module vsl_isqrt
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);
    import vsl_pkg::*;

    logic [63:0] n_reg;
    logic [63:0] root_reg;
    logic [63:0] bit_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] trial;
    logic        fits;

    assign trial = root_reg + bit_reg;
    assign fits  = n_reg >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg    <= radicand;
            root_reg <= '0;
            bit_reg  <= 64'h4000_0000_0000_0000;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                n_reg    <= n_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = root_reg[31:0];

endmodule

@@ bench/velocity_setpoint_limit_accel_filter_core_test.sv @@
`timescale 1ns / 1ps

module velocity_setpoint_limit_accel_filter_core_test;
    import vsl_pkg::*;

    // Long enough for an update with horizontal scaling, with margin.
    localparam int SETTLE_CYCLES = 800;
    localparam int CYCLE_LIMIT   = 4000000;
    localparam int PHASE_ITEMS   = 200;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_t         in_data;
    logic        out_valid;
    logic        out_ready;
    out_t        out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    velocity_setpoint_limit_accel_filter_core u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Setpoint beats still to be sent, and results the limiter must produce.
    in_t  pending_cmds[$];
    out_t expected_results[$];

    // Shadow of the block: limits, time constant, kept velocity, filter state.
    longint unsigned lim_horiz;
    longint unsigned lim_vert;
    longint unsigned lim_turn;
    longint unsigned tau_us;
    longint          kept_vel[3];
    longint          filt_accel[3];

    int  fail_count;
    int  update_count;
    int  activate_count;
    int  result_count;
    int  cycle_count;
    bit  quiet;         // no idling on either side
    bit  in_took;       // input beat accepted at the last rising edge
    int  in_gap;
    int  out_stall;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic longint sat_i32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint clamp_abs(longint v, longint unsigned lim);
        longint l;
        l = longint'(lim);
        if (v > l)
            return l;
        if (v < -l)
            return -l;
        return v;
    endfunction

    // Limit the setpoint, advance the acceleration filter, queue the result.
    task automatic limit_and_filter(input in_t beat);
        longint          v[3];
        longint          yaw;
        longint          raw;
        longint          stp;
        longint          mag_a;
        longint          scaled;
        longint unsigned m2;
        longint unsigned l2;
        longint unsigned n;
        longint unsigned root;
        longint unsigned bitv;
        longint unsigned dt;
        longint unsigned den;
        out_t            res;
        v[0] = longint'(beat.vel_x);
        v[1] = longint'(beat.vel_y);
        v[2] = longint'(beat.vel_z);
        yaw  = longint'(beat.turn_rate);
        dt   = longint'(beat.step_time_us);
        if (cmd_t'(beat.cmd) == CMD_ACTIVATE)
        begin
            for (int i = 0; i < 3; i++)
            begin
                kept_vel[i]   = v[i];
                filt_accel[i] = 0;
            end
            activate_count++;
            return;
        end
        update_count++;
        m2 = longint'(v[0] * v[0]) + longint'(v[1] * v[1]);
        l2 = lim_horiz * lim_horiz;
        if (m2 > l2)
        begin
            // floor square root, bit by bit
            n    = m2;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > n)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (n >= root + bitv)
                begin
                    n    = n - (root + bitv);
                    root = (root >> 1) + bitv;
                end
                else
                    root = root >> 1;
                bitv = bitv >> 2;
            end
            for (int i = 0; i < 2; i++)
            begin
                mag_a  = (v[i] < 0) ? -v[i] : v[i];
                scaled = longint'((longint'(mag_a) * lim_horiz) / root);
                v[i]   = (v[i] < 0) ? -scaled : scaled;
            end
        end
        v[2] = clamp_abs(v[2], lim_vert);
        yaw  = clamp_abs(yaw, lim_turn);
        den  = dt + tau_us;
        for (int i = 0; i < 3; i++)
        begin
            raw = 0;
            if (dt != 0)
                raw = sat_i32(((v[i] - kept_vel[i]) * 64'sd1000000) / longint'(dt));
            kept_vel[i] = v[i];
            if (den != 0)
            begin
                stp = ((raw - filt_accel[i]) * longint'(dt)) / longint'(den);
                filt_accel[i] = sat_i32(filt_accel[i] + stp);
            end
        end
        res.lim_vel_x     = v[0][31:0];
        res.lim_vel_y     = v[1][31:0];
        res.lim_vel_z     = v[2][31:0];
        res.lim_turn_rate = yaw[31:0];
        res.accel_x       = filt_accel[0][31:0];
        res.accel_y       = filt_accel[1][31:0];
        res.accel_z       = filt_accel[2][31:0];
        expected_results.push_back(res);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_count++;
        $display("mismatch on %s: got %08h, expected %08h (result %0d)",
                 what, got, want, result_count);
    endtask

    // Monitor: predict on each accepted setpoint beat, check each result beat.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("velocity_setpoint_limit_accel_filter_core_test: FAIL");
            $finish;
        end
        in_took <= rst_n && in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
            limit_and_filter(in_data);
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                fail_count++;
                $display("result beat with nothing expected: %h", out_data);
            end
            else
            begin
                out_t want;
                want = expected_results.pop_front();
                if (out_data.lim_vel_x !== want.lim_vel_x)
                    report_mismatch("lim_vel_x", out_data.lim_vel_x, want.lim_vel_x);
                if (out_data.lim_vel_y !== want.lim_vel_y)
                    report_mismatch("lim_vel_y", out_data.lim_vel_y, want.lim_vel_y);
                if (out_data.lim_vel_z !== want.lim_vel_z)
                    report_mismatch("lim_vel_z", out_data.lim_vel_z, want.lim_vel_z);
                if (out_data.lim_turn_rate !== want.lim_turn_rate)
                    report_mismatch("lim_turn_rate", out_data.lim_turn_rate,
                                    want.lim_turn_rate);
                if (out_data.accel_x !== want.accel_x)
                    report_mismatch("accel_x", out_data.accel_x, want.accel_x);
                if (out_data.accel_y !== want.accel_y)
                    report_mismatch("accel_y", out_data.accel_y, want.accel_y);
                if (out_data.accel_z !== want.accel_z)
                    report_mismatch("accel_z", out_data.accel_z, want.accel_z);
            end
            result_count++;
        end
    end

    // Driver: inputs move on the falling edge; valid holds until the beat is taken.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            out_ready <= 1'b0;
        end
        else
        begin
            if (!in_valid || in_took)
            begin
                if (in_gap > 0)
                begin
                    in_gap   <= in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_cmds.size() != 0)
                begin
                    in_data  <= pending_cmds.pop_front();
                    in_valid <= 1'b1;
                    if (!quiet && $urandom_range(0, 3) == 0)
                        in_gap <= $urandom_range(1, 4);
                end
                else
                    in_valid <= 1'b0;
            end
            // result side back-pressure, in short bursts
            if (out_stall > 0)
            begin
                out_stall <= out_stall - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 7) == 0)
                    out_stall <= $urandom_range(1, 4);
            end
        end
    end

    // Configuration writes: setup cycle, then access cycle.
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            REG_MAX_HORIZ: lim_horiz = value & 32'h7FFF_FFFF;
            REG_MAX_VERT:  lim_vert  = value & 32'h7FFF_FFFF;
            REG_MAX_TURN:  lim_turn  = value & 32'h7FFF_FFFF;
            REG_TAU:       tau_us    = value & 32'h00FF_FFFF;
            default: ;
        endcase
    endtask

    // Wait until every beat is sent and answered, then let an activate settle.
    task automatic wait_idle();
        while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic push_cmd(input cmd_t c, input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z, input logic [31:0] w,
                            input logic [19:0] dt);
        in_t b;
        b.cmd          = c;
        b.vel_x        = x;
        b.vel_y        = y;
        b.vel_z        = z;
        b.turn_rate    = w;
        b.step_time_us = dt;
        pending_cmds.push_back(b);
    endtask

    // Mostly values near the limits, sometimes anything in the 32-bit range.
    function automatic logic [31:0] pick_speed(longint unsigned lim);
        int unsigned span;
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return 32'd0;
            default:
            begin
                span = (lim > 64'h3FFF_FFFF || lim == 0) ? 32'h0004_0000 : 2 * lim + 1;
                return $urandom_range(0, span) - span / 2;
            end
        endcase
    endfunction

    function automatic logic [19:0] pick_dt();
        case ($urandom_range(0, 9))
            0: return 20'd0;
            1: return $urandom;
            2: return 20'd1;
            default: return $urandom_range(1000, 20000);
        endcase
    endfunction

    task automatic random_phase(input int count);
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 11) == 0)
                push_cmd(CMD_ACTIVATE, pick_speed(lim_horiz), pick_speed(lim_horiz),
                         pick_speed(lim_vert), $urandom, $urandom);
            else
                push_cmd(CMD_UPDATE, pick_speed(lim_horiz), pick_speed(lim_horiz),
                         pick_speed(lim_vert), pick_speed(lim_turn), pick_dt());
        end
        wait_idle();
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        out_ready  = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        fail_count = 0;
        update_count   = 0;
        activate_count = 0;
        result_count   = 0;
        cycle_count    = 0;
        quiet      = 1'b0;
        in_gap     = 0;
        out_stall  = 0;
        lim_horiz  = 32768;
        lim_vert   = 32768;
        lim_turn   = 22876;
        tau_us     = 100000;
        for (int i = 0; i < 3; i++)
        begin
            kept_vel[i]   = 0;
            filt_accel[i] = 0;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset limits, field extremes, zero and extreme step times.
        push_cmd(CMD_UPDATE, 0, 0, 0, 0, 0);
        push_cmd(CMD_UPDATE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 20'd1);
        push_cmd(CMD_UPDATE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 20'd1);
        push_cmd(CMD_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 20'd1000000);
        push_cmd(CMD_UPDATE, 32'h0000_4000, 32'hFFFF_C000, 32'h0000_1000,
                 32'hFFFF_F000, 20'd10000);
        push_cmd(CMD_UPDATE, 32'h0000_8000, 0, 32'h0000_8000, 32'd22876, 20'hFFFFF);
        push_cmd(CMD_UPDATE, 0, 32'hFFFF_8000, 32'hFFFF_8000, -32'sd22876, 20'd0);
        push_cmd(CMD_UPDATE, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000,
                 32'h0010_0000, 20'd5000);
        // activate loads unlimited history and clears the filter
        push_cmd(CMD_ACTIVATE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'hFFFF_FFFF, 20'hFFFFF);
        push_cmd(CMD_UPDATE, 0, 0, 0, 0, 20'd1);
        push_cmd(CMD_ACTIVATE, 0, 0, 0, 0, 0);
        push_cmd(CMD_ACTIVATE, 32'h0000_1000, 32'h0000_2000, 32'hFFFF_0000, 0, 0);
        push_cmd(CMD_UPDATE, 32'h0000_1000, 32'h0000_2000, 32'hFFFF_F000, 0, 20'd0);
        push_cmd(CMD_UPDATE, 32'h0000_3000, 32'h0000_1000, 32'h0000_3000,
                 32'h0000_5000, 20'd2500);
        wait_idle();

        // Zero limits and zero time constant: every value clamps to zero and a
        // zero step time keeps the filter as it is.
        write_reg(REG_MAX_HORIZ, 32'd0);
        write_reg(REG_MAX_VERT, 32'd0);
        write_reg(REG_MAX_TURN, 32'd0);
        write_reg(REG_TAU, 32'd0);
        push_cmd(CMD_ACTIVATE, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000, 0, 0);
        push_cmd(CMD_UPDATE, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                 32'h0001_0000, 20'd0);
        push_cmd(CMD_UPDATE, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                 32'h0001_0000, 20'd100);
        random_phase(PHASE_ITEMS);

        // All ones written: the upper bits are dropped by the register widths.
        write_reg(REG_MAX_HORIZ, 32'hFFFF_FFFF);
        write_reg(REG_MAX_VERT, 32'hFFFF_FFFF);
        write_reg(REG_MAX_TURN, 32'hFFFF_FFFF);
        write_reg(REG_TAU, 32'hFFFF_FFFF);
        random_phase(PHASE_ITEMS);

        // Moderate limits, time constant up to 10000000 us.
        for (int p = 0; p < 4; p++)
        begin
            write_reg(REG_MAX_HORIZ, $urandom_range(1, 32'h0004_0000));
            write_reg(REG_MAX_VERT, $urandom_range(1, 32'h0004_0000));
            write_reg(REG_MAX_TURN, $urandom_range(1, 32'h0004_0000));
            write_reg(REG_TAU, (p == 3) ? 32'd10000000 : $urandom_range(0, 300000));
            quiet = (p == 3);
            random_phase(PHASE_ITEMS);
        end

        $display("covered %0d updates and %0d activates over seven limit settings",
                 update_count, activate_count);
        $display("%0d result beats checked, %0d mismatches", result_count, fail_count);
        if (fail_count == 0)
            $display("velocity_setpoint_limit_accel_filter_core_test: PASS");
        else
            $display("velocity_setpoint_limit_accel_filter_core_test: FAIL");
        $finish;
    end

endmodule
